>>> rtl/cdiv_pkg.sv
// ----------------------------------------------------------------------------
// cdiv_pkg
// Shared types and constants of the complex divider pipeline.
// ----------------------------------------------------------------------------
package cdiv_pkg;

    // Width of the magnitude of a dot product (|p| and |q| are at most 2^31).
    localparam int MAG_W = 32;
    // Extra zero bits shifted in below the magnitude: 16 for Q16.16 plus
    // one for the half-step used by rounding.
    localparam int FRAC_W = 17;
    // Dividend bits and long-division steps per lane.
    localparam int NUM_W = MAG_W + FRAC_W;
    localparam int DIV_STEPS = NUM_W;
    // Quotient register width before the sticky high-bit flag.
    localparam int QUO_W = 34;

    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;

    // One request: the dividend and the divisor.
    typedef struct packed {
        logic signed [15:0] dividend_real;
        logic signed [15:0] dividend_imag;
        logic signed [15:0] divisor_real;
        logic signed [15:0] divisor_imag;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic signed [31:0] quotient_real;
        logic signed [31:0] quotient_imag;
        logic               overflow;
    } out_item_t;

    // State of one long-division lane.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             big;
        logic [NUM_W-1:0] num;
    } lane_t;

    // Everything that travels down the divider stages.
    typedef struct packed {
        logic [31:0] den;
        logic        zero;
        logic        re_neg;
        logic        im_neg;
        lane_t       re;
        lane_t       im;
    } div_item_t;

endpackage

>>> rtl/cdiv_stream_if.sv
// ----------------------------------------------------------------------------
// cdiv_stream_if
// Valid/ready channel that carries one payload per request.
// ----------------------------------------------------------------------------
interface cdiv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

>>> rtl/complex_divider.sv
// ----------------------------------------------------------------------------
// complex_divider
// Pipelined complex division of Q1.15 operands to Q16.16 quotients.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  din      sink       dividend_real, dividend_imag, divisor_real, divisor_imag
//  dout     source     quotient_real, quotient_imag, overflow
//
//  One request is accepted per cycle while din.ready is high. A result passes
//  two multiply/sum stages, 49 long-division stages (one quotient bit each),
//  one rounding stage and the output register. A skid register behind the
//  output register lets the pipeline advance while a result waits; the
//  pipeline and din.ready halt only when both are full. Reset clears the
//  valid bits only.
// ----------------------------------------------------------------------------
module complex_divider (
    input  logic          clk,
    input  logic          rst_n,
    cdiv_stream_if.sink   din,
    cdiv_stream_if.source dout
);

    localparam int NS = cdiv_pkg::DIV_STEPS;

    logic                en;
    logic                front_valid;
    cdiv_pkg::div_item_t front_data;
    logic                step_valid [NS+1];
    cdiv_pkg::div_item_t step_data  [NS+1];
    logic                last_valid;
    cdiv_pkg::out_item_t last_data;

    logic                out_valid_reg;
    cdiv_pkg::out_item_t out_data_reg;
    logic                skid_valid_reg;
    cdiv_pkg::out_item_t skid_data_reg;
    logic                push;
    logic                out_free;

    // The pipeline advances unless the skid register is occupied.
    assign en        = !skid_valid_reg;
    assign din.ready = en;

    cdiv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (din.valid),
        .in_data   (din.data),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    assign step_valid[0] = front_valid;
    assign step_data[0]  = front_data;

    // Long-division stages, one quotient bit each.
    for (genvar i = 0; i < NS; i++)
    begin : g_step
        cdiv_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (step_valid[i]),
            .in_data   (step_data[i]),
            .out_valid (step_valid[i+1]),
            .out_data  (step_data[i+1])
        );
    end

    cdiv_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (step_valid[NS]),
        .in_data   (step_data[NS]),
        .out_valid (last_valid),
        .out_data  (last_data)
    );

    // Output register with skid register behind it.
    assign push     = last_valid && en;
    assign out_free = !out_valid_reg || dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : last_data;
        end
        else if (push)
        begin
            skid_data_reg <= last_data;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.data  = out_data_reg;

endmodule

>>> rtl/cdiv_front.sv
// ----------------------------------------------------------------------------
// cdiv_front
// Two register stages: the six products, then the squared divisor magnitude,
// the two dot products and the initial state of both division lanes.
// ----------------------------------------------------------------------------
module cdiv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cdiv_pkg::in_item_t   in_data,
    output logic                 out_valid,
    output cdiv_pkg::div_item_t  out_data
);

    logic               a_valid_reg;
    logic signed [31:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;
    logic               b_valid_reg;
    cdiv_pkg::div_item_t b_data_reg;
    cdiv_pkg::div_item_t b_data_next;

    logic [31:0]        y;
    logic signed [32:0] p;
    logic signed [32:0] q;
    logic [32:0]        p_abs;
    logic [32:0]        q_abs;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg <= in_data.dividend_real * in_data.divisor_real;
            bd_reg <= in_data.dividend_imag * in_data.divisor_imag;
            bc_reg <= in_data.dividend_imag * in_data.divisor_real;
            ad_reg <= in_data.dividend_real * in_data.divisor_imag;
            cc_reg <= in_data.divisor_real * in_data.divisor_real;
            dd_reg <= in_data.divisor_imag * in_data.divisor_imag;
        end
    end

    // Sums and magnitudes; each square is at most 2^30, so y fits 32 bits.
    always_comb
    begin
        y = 32'(cc_reg) + 32'(dd_reg);
        p = 33'(ac_reg) + 33'(bd_reg);
        q = 33'(bc_reg) - 33'(ad_reg);
        p_abs = p[32] ? 33'(-p) : 33'(p);
        q_abs = q[32] ? 33'(-q) : 33'(q);

        b_data_next.den    = y;
        b_data_next.zero   = (y == 32'd0);
        b_data_next.re_neg = p[32];
        b_data_next.im_neg = q[32];
        b_data_next.re.rem = '0;
        b_data_next.re.quo = '0;
        b_data_next.re.big = 1'b0;
        b_data_next.re.num = {p_abs[cdiv_pkg::MAG_W-1:0], {cdiv_pkg::FRAC_W{1'b0}}};
        b_data_next.im.rem = '0;
        b_data_next.im.quo = '0;
        b_data_next.im.big = 1'b0;
        b_data_next.im.num = {q_abs[cdiv_pkg::MAG_W-1:0], {cdiv_pkg::FRAC_W{1'b0}}};
    end

    // Sum stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

>>> rtl/cdiv_div_step.sv
// ----------------------------------------------------------------------------
// cdiv_div_step
// One registered restoring-division step for both quotient lanes.
// ----------------------------------------------------------------------------
module cdiv_div_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cdiv_pkg::div_item_t  in_data,
    output logic                 out_valid,
    output cdiv_pkg::div_item_t  out_data
);

    logic                valid_reg;
    cdiv_pkg::div_item_t data_reg;
    cdiv_pkg::div_item_t data_next;

    // Shift one dividend bit into the remainder and subtract if it fits.
    function automatic cdiv_pkg::lane_t step(input cdiv_pkg::lane_t l, input logic [31:0] den);
        cdiv_pkg::lane_t r;
        logic [32:0]     trial;
        logic [32:0]     diff;
        logic            ge;
        trial = {l.rem, l.num[cdiv_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
        r.rem = ge ? diff[31:0] : trial[31:0];
        r.quo = {l.quo[cdiv_pkg::QUO_W-2:0], ge};
        r.big = l.big | l.quo[cdiv_pkg::QUO_W-1];
        r.num = {l.num[cdiv_pkg::NUM_W-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        data_next    = in_data;
        data_next.re = step(in_data.re, in_data.den);
        data_next.im = step(in_data.im, in_data.den);
    end

    // Valid bit of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of this stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cdiv_round.sv
// ----------------------------------------------------------------------------
// cdiv_round
// Final stage: rounds both quotients, applies signs and saturation.
// ----------------------------------------------------------------------------
module cdiv_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cdiv_pkg::div_item_t  in_data,
    output logic                 out_valid,
    output cdiv_pkg::out_item_t  out_data
);

    logic                valid_reg;
    cdiv_pkg::out_item_t data_reg;
    cdiv_pkg::out_item_t data_next;

    logic [cdiv_pkg::QUO_W:0] re_sum;
    logic [cdiv_pkg::QUO_W:0] im_sum;
    logic [cdiv_pkg::QUO_W-1:0] re_r;
    logic [cdiv_pkg::QUO_W-1:0] im_r;
    logic re_ovf;
    logic im_ovf;
    logic ovf;

    // The quotient holds twice the ratio; adding one and halving rounds
    // half away from zero on the magnitude.
    always_comb
    begin
        re_sum = {1'b0, in_data.re.quo} + 1'b1;
        im_sum = {1'b0, in_data.im.quo} + 1'b1;
        re_r   = re_sum[cdiv_pkg::QUO_W:1];
        im_r   = im_sum[cdiv_pkg::QUO_W:1];

        // A negative part may reach 2^31; a positive one stops at 2^31 - 1.
        re_ovf = in_data.re.big || (re_r[cdiv_pkg::QUO_W-1:31] != '0 &&
                 !(in_data.re_neg && re_r[cdiv_pkg::QUO_W-1:32] == '0 && re_r[30:0] == '0));
        im_ovf = in_data.im.big || (im_r[cdiv_pkg::QUO_W-1:31] != '0 &&
                 !(in_data.im_neg && im_r[cdiv_pkg::QUO_W-1:32] == '0 && im_r[30:0] == '0));
        ovf    = in_data.zero || re_ovf || im_ovf;

        data_next.overflow = ovf;
        if (ovf)
        begin
            data_next.quotient_real = in_data.re_neg ? cdiv_pkg::Q_NEG_MAX : cdiv_pkg::Q_POS_MAX;
            data_next.quotient_imag = in_data.im_neg ? cdiv_pkg::Q_NEG_MAX : cdiv_pkg::Q_POS_MAX;
        end
        else
        begin
            data_next.quotient_real = in_data.re_neg ? 32'(32'd0 - re_r[31:0]) : re_r[31:0];
            data_next.quotient_imag = in_data.im_neg ? 32'(32'd0 - im_r[31:0]) : im_r[31:0];
        end
    end

    // Valid bit of the rounding stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the rounding stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/cdiv_checker.sv
// ----------------------------------------------------------------------------
// cdiv_checker
// Port-level checks of the complex divider, bound to the top level.
// ----------------------------------------------------------------------------
module cdiv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input cdiv_pkg::out_item_t out_data
);

    // Requests in flight: accepted but not yet delivered.
    logic [6:0] count_reg;
    logic [6:0] count_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = in_valid && in_ready;
    assign acc_out = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg + 7'(acc_in) - 7'(acc_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A result never appears without a request behind it.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 7'd0)
        else $error("result without an outstanding request");

    // The pipeline never holds more than its stages plus the two output slots.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'd54)
        else $error("more requests in flight than storage");

    // Backpressure reaches the input only while a result is waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready || out_valid)
        else $error("input stalled with no result waiting");

    // A flagged result carries saturated parts only.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |->
        (out_data.quotient_real == cdiv_pkg::Q_POS_MAX ||
         out_data.quotient_real == cdiv_pkg::Q_NEG_MAX) &&
        (out_data.quotient_imag == cdiv_pkg::Q_POS_MAX ||
         out_data.quotient_imag == cdiv_pkg::Q_NEG_MAX))
        else $error("overflow set on an unsaturated result");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind complex_divider cdiv_checker u_cdiv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (dout.data)
);
